### hw/rtl/positional_array_list_core_macros.svh
// Assertion macros used by the positional array list core.
`ifndef POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define PALC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("palc assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define PALC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palc sequence assertion failed");

`endif

### hw/rtl/palc_pkg.sv
// Types and codes shared by the positional array list core and its cells.
`default_nettype none

package palc_pkg;

	typedef enum logic [3:0] {
		OP_INS_HEAD = 4'd0,
		OP_INS_AT   = 4'd1,
		OP_INS_TAIL = 4'd2,
		OP_SWAP     = 4'd3,
		OP_EDIT     = 4'd4,
		OP_REM_HEAD = 4'd5,
		OP_REM_TAIL = 4'd6,
		OP_REM_AT   = 4'd7,
		OP_READ     = 4'd8
	} op_e;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_SAME   = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GATHER,
		S_APPLY
	} state_e;

	typedef struct packed {
		logic [3:0]         op;
		logic [6:0]         position;
		logic [6:0]         second_position;
		logic signed [31:0] entry_code;
		logic [15:0]        entry_year;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] out_code;
		logic [15:0]        out_year;
		logic [7:0]         count;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] code;
		logic [15:0]        year;
	} entry_t;

	// Row-wide action, at most one flag set.
	typedef struct packed {
		logic ins;
		logic rem;
		logic swap;
		logic edit;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/positional_array_list_core.sv
// Top level of the positional array list: control, status, count and the row of cells.
`default_nettype none

// Ordered list of up to CAPACITY records kept densely from position 0 in a row of
// cells, one record per cell. A request is taken when start is high and busy is low;
// busy then stays high through the gather and apply states, and done, registered from
// apply, pulses for one cycle with the result on result. The gather state gathers the
// addressed records from the row over a one-hot tap bus and settles status; the apply
// state applies the shift, write or swap to every cell at once and updates the count.
// The receiver cannot stall: result is valid only while done is high. Every request
// yields exactly one result, including failed and unused ops.
module positional_array_list_core import palc_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      done,
	output rsp_t      result
);

	`include "positional_array_list_core_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	state_e         state_q;
	state_e         state_d;
	logic           accept;
	logic           gather;
	logic           apply;

	req_t           req_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic [PW-1:0]  cnt_w;
	logic [PW-1:0]  p1;
	logic [PW-1:0]  p2;
	logic [PW-1:0]  at;

	logic [2:0]     status_c;
	cell_ctrl_t     act_c;
	logic           have_c;
	logic [2:0]     status_q;
	cell_ctrl_t     act_q;
	logic           have_q;
	entry_t         rd1_q;
	entry_t         rd2_q;

	cell_ctrl_t     cell_ctrl;
	entry_t         wr_data;
	entry_t         bus1;
	entry_t         bus2;
	entry_t         cell_entry [CAPACITY];
	entry_t         cell_tap1  [CAPACITY];
	entry_t         cell_tap2  [CAPACITY];

	logic           done_q;
	rsp_t           rsp_q;

	// state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_GATHER;
			S_GATHER: state_d = S_APPLY;
			S_APPLY:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		accept = 1'b0;
		gather = 1'b0;
		apply  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			S_GATHER: gather = 1'b1;
			S_APPLY:  apply  = 1'b1;
			default:  busy   = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	assign cnt_w = PW'(count_q);
	assign p1    = PW'(req_q.position);
	assign p2    = PW'(req_q.second_position);

	// target slot of the request
	always_comb begin
		unique case (req_q.op) inside
			OP_INS_HEAD, OP_REM_HEAD: at = '0;
			OP_INS_TAIL:              at = cnt_w;
			OP_REM_TAIL:              at = cnt_w - PW'(1);
			default:                  at = p1;
		endcase
	end

	// status and action decode
	always_comb begin
		status_c = ST_OK;
		act_c    = '0;
		have_c   = 1'b0;
		unique case (req_q.op) inside
			OP_INS_HEAD, OP_INS_AT, OP_INS_TAIL: begin
				if (count_q >= CW'(CAPACITY)) begin
					status_c = ST_FULL;
				end else if (at > cnt_w) begin
					status_c = ST_BADPOS;
				end else begin
					act_c.ins = 1'b1;
				end
			end
			OP_SWAP: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
				end else if (p1 >= cnt_w || p2 >= cnt_w) begin
					status_c = ST_BADPOS;
				end else if (p1 == p2) begin
					status_c = ST_SAME;
				end else begin
					act_c.swap = 1'b1;
				end
			end
			OP_EDIT, OP_READ: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
				end else if (p1 >= cnt_w) begin
					status_c = ST_BADPOS;
				end else if (req_q.op == OP_EDIT) begin
					act_c.edit = 1'b1;
				end else begin
					have_c = 1'b1;
				end
			end
			OP_REM_HEAD, OP_REM_TAIL, OP_REM_AT: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
				end else if (at >= cnt_w) begin
					status_c = ST_BADPOS;
				end else begin
					act_c.rem = 1'b1;
					have_c    = 1'b1;
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	// collect the addressed records from the row
	always_comb begin
		bus1 = '0;
		bus2 = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			bus1 = bus1 | cell_tap1[i];
			bus2 = bus2 | cell_tap2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (gather) begin
			status_q <= status_c;
			have_q   <= have_c;
			rd1_q    <= bus1;
			rd2_q    <= bus2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (gather) begin
			act_q <= act_c;
		end
	end

	assign cell_ctrl       = apply ? act_q : '0;
	assign wr_data.code    = req_q.entry_code;
	assign wr_data.year    = req_q.entry_year;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t left_n;
		entry_t right_n;
		if (g == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = cell_entry[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_n = '0;
		end else begin : g_mid_r
			assign right_n = cell_entry[g+1];
		end
		palc_cell #(
			.PW    (PW),
			.INDEX (g)
		) u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.at      (at),
			.at2     (p2),
			.wr_data (wr_data),
			.swap1   (rd1_q),
			.swap2   (rd2_q),
			.left    (left_n),
			.right   (right_n),
			.entry   (cell_entry[g]),
			.tap1    (cell_tap1[g]),
			.tap2    (cell_tap2[g])
		);
	end

	always_comb begin
		count_d = count_q;
		if (cell_ctrl.ins) begin
			count_d = count_q + CW'(1);
		end else if (cell_ctrl.rem) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= apply;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			rsp_q.status   <= status_q;
			rsp_q.out_code <= have_q ? rd1_q.code : '0;
			rsp_q.out_year <= have_q ? rd1_q.year : '0;
			rsp_q.count    <= 8'(count_d);
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	`PALC_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	`PALC_ASSERT_NEXT(a_accept_gathers, start && !busy, state_q == S_GATHER)
	`PALC_ASSERT_NEXT(a_apply_done, state_q == S_APPLY, done && !busy)
	`PALC_ASSERT_NEXT(a_count_hold, state_q != S_APPLY, $stable(count_q))
	`PALC_ASSERT_NEXT(a_ins_count, apply && act_q.ins, count_q == $past(count_q) + CW'(1))

endmodule

`default_nettype wire

### hw/rtl/palc_cell.sv
// One list slot: holds a record and takes it from a neighbor, the request or a swap source.
`default_nettype none

module palc_cell import palc_pkg::*; #(
	parameter int PW    = 8,
	parameter int INDEX = 0
) (
	input  wire logic            clk,
	input  wire cell_ctrl_t      ctrl,
	input  wire logic [PW-1:0]   at,
	input  wire logic [PW-1:0]   at2,
	input  wire entry_t          wr_data,
	input  wire entry_t          swap1,
	input  wire entry_t          swap2,
	input  wire entry_t          left,
	input  wire entry_t          right,
	output entry_t               entry,
	output entry_t               tap1,
	output entry_t               tap2
);

	localparam logic [PW-1:0] IDX = PW'(INDEX);

	entry_t entry_q;
	entry_t entry_d;
	logic   hit1;
	logic   hit2;

	assign hit1 = (at == IDX);
	assign hit2 = (at2 == IDX);

	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins) begin
			if (hit1) begin
				entry_d = wr_data;
			end else if (at < IDX) begin
				entry_d = left;
			end
		end else if (ctrl.rem) begin
			// close the gap: every slot from the removed one up takes its upper neighbor
			if (!(IDX < at)) begin
				entry_d = right;
			end
		end else if (ctrl.swap) begin
			if (hit1) begin
				entry_d = swap2;
			end else if (hit2) begin
				entry_d = swap1;
			end
		end else if (ctrl.edit) begin
			if (hit1) begin
				entry_d = wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign tap1  = hit1 ? entry_q : '0;
	assign tap2  = hit2 ? entry_q : '0;

endmodule

`default_nettype wire
